FILE: src/amat_pkg.sv
// Shared types, register codes and threshold lookup functions for the
// multichannel ADC averaging block. No dependencies.
package amat_pkg;

    localparam int CH_W   = 3;
    localparam int THR_W  = 16;
    localparam int SUM_W  = 16;
    localparam int CFG_W  = 64;
    localparam int HI_W   = 48;
    localparam int MASK_W = 7;

    typedef enum logic [CH_W-1:0] {
        CFG_UPPER_LO = 3'd0,
        CFG_UPPER_HI = 3'd1,
        CFG_LOWER_LO = 3'd2,
        CFG_LOWER_HI = 3'd3,
        CFG_SAFETY   = 3'd4
    } cfg_index_t;

    localparam logic [CFG_W-1:0]  UPPER_LO_RST = 64'h09C4_09C4_09C4_09C4;
    localparam logic [HI_W-1:0]   UPPER_HI_RST = 48'h09C4_09C4_09C4;
    localparam logic [CFG_W-1:0]  LOWER_LO_RST = 64'h0000_03E8_03E8_0064;
    localparam logic [HI_W-1:0]   LOWER_HI_RST = 48'h03E8_03E8_0000;
    localparam logic [MASK_W-1:0] SAFETY_RST   = 7'h66;

    localparam logic [THR_W-1:0] UPPER_NONE = 16'hFFFF;
    localparam logic [THR_W-1:0] LOWER_NONE = 16'h0000;

    typedef struct packed {
        logic [CFG_W-1:0]  upper_lo;
        logic [HI_W-1:0]   upper_hi;
        logic [CFG_W-1:0]  lower_lo;
        logic [HI_W-1:0]   lower_hi;
        logic [MASK_W-1:0] mask;
    } thr_t;

    typedef struct packed {
        logic in_range;
        logic raw_above;
        logic raw_below;
    } class_t;

    function automatic logic [THR_W-1:0] pick16(
        input logic [CFG_W-1:0] lo,
        input logic [HI_W-1:0]  hi,
        input logic [CH_W-1:0]  ch,
        input logic [THR_W-1:0] none
    );
        logic [THR_W-1:0] r;
        unique case (ch)
            3'd0:    r = lo[15:0];
            3'd1:    r = lo[31:16];
            3'd2:    r = lo[47:32];
            3'd3:    r = lo[63:48];
            3'd4:    r = hi[15:0];
            3'd5:    r = hi[31:16];
            3'd6:    r = hi[47:32];
            default: r = none;
        endcase
        return r;
    endfunction

    function automatic logic [THR_W-1:0] upper_of(input thr_t t, input logic [CH_W-1:0] ch);
        return pick16(t.upper_lo, t.upper_hi, ch, UPPER_NONE);
    endfunction

    function automatic logic [THR_W-1:0] lower_of(input thr_t t, input logic [CH_W-1:0] ch);
        return pick16(t.lower_lo, t.lower_hi, ch, LOWER_NONE);
    endfunction

endpackage

FILE: src/amat_config.sv
// Threshold and safety mask registers written through the plain write port.
// Depends on amat_pkg.
module amat_config (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [amat_pkg::CH_W-1:0]          cfg_index,
    input  logic [amat_pkg::CFG_W-1:0]         cfg_data,
    output amat_pkg::thr_t                     thr
);

    amat_pkg::thr_t thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.upper_lo <= amat_pkg::UPPER_LO_RST;
            thr_reg.upper_hi <= amat_pkg::UPPER_HI_RST;
            thr_reg.lower_lo <= amat_pkg::LOWER_LO_RST;
            thr_reg.lower_hi <= amat_pkg::LOWER_HI_RST;
            thr_reg.mask     <= amat_pkg::SAFETY_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                amat_pkg::CFG_UPPER_LO: thr_reg.upper_lo <= cfg_data;
                amat_pkg::CFG_UPPER_HI: thr_reg.upper_hi <= cfg_data[amat_pkg::HI_W-1:0];
                amat_pkg::CFG_LOWER_LO: thr_reg.lower_lo <= cfg_data;
                amat_pkg::CFG_LOWER_HI: thr_reg.lower_hi <= cfg_data[amat_pkg::HI_W-1:0];
                amat_pkg::CFG_SAFETY:   thr_reg.mask     <= cfg_data[amat_pkg::MASK_W-1:0];
                default:                thr_reg          <= thr_reg;
            endcase
        end
    end

    assign thr = thr_reg;

endmodule

FILE: src/amat_front.sv
// Input side: accepts samples, classifies the raw value against the channel
// thresholds and holds up to two classified samples. Depends on amat_pkg.
module amat_front #(
    parameter int CHANNELS    = 7,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  amat_pkg::thr_t                thr,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [amat_pkg::CH_W-1:0]     channel,
    input  logic [SAMPLE_BITS-1:0]        sample,
    output logic                          head_valid,
    output logic [amat_pkg::CH_W-1:0]     head_channel,
    output logic [SAMPLE_BITS-1:0]        head_sample,
    output amat_pkg::class_t              head_class,
    input  logic                          pop
);

    logic [amat_pkg::CH_W-1:0] chan_q [2];
    logic [SAMPLE_BITS-1:0]    samp_q [2];
    amat_pkg::class_t          class_q [2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    amat_pkg::class_t in_class;
    logic [amat_pkg::THR_W-1:0] raw_ext;

    assign sample_stall = (count_reg == 2'd2);
    assign push         = sample_valid && !sample_stall;
    assign raw_ext      = amat_pkg::THR_W'(sample);

    always_comb
    begin
        in_class.in_range  = (int'(channel) < CHANNELS);
        in_class.raw_above = in_class.in_range && (raw_ext > amat_pkg::upper_of(thr, channel));
        in_class.raw_below = in_class.in_range && (raw_ext < amat_pkg::lower_of(thr, channel));
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            chan_q[wr_ptr_reg]  <= channel;
            samp_q[wr_ptr_reg]  <= sample;
            class_q[wr_ptr_reg] <= in_class;
        end
    end

    assign head_valid   = (count_reg != 2'd0);
    assign head_channel = chan_q[rd_ptr_reg];
    assign head_sample  = samp_q[rd_ptr_reg];
    assign head_class   = class_q[rd_ptr_reg];

`ifndef ASSERT_OFF
    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg != 2'd0)
        else $error("queue empty after a transfer in");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count beyond its depth");
`endif

endmodule

FILE: src/amat_back.sv
// Per-channel running-average state, update datapath and result register.
// Depends on amat_pkg.
module amat_back #(
    parameter int CHANNELS    = 7,
    parameter int AVG_COUNT   = 10,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  amat_pkg::thr_t                thr,
    input  logic                          head_valid,
    input  logic [amat_pkg::CH_W-1:0]     head_channel,
    input  logic [SAMPLE_BITS-1:0]        head_sample,
    input  amat_pkg::class_t              head_class,
    output logic                          pop,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [amat_pkg::CH_W-1:0]     out_channel,
    output logic [SAMPLE_BITS-1:0]        raw_value,
    output logic [SAMPLE_BITS-1:0]        filtered_value,
    output logic                          filter_ready,
    output logic                          raw_above_upper,
    output logic                          raw_below_lower,
    output logic                          filtered_above_upper,
    output logic                          filtered_below_lower,
    output logic                          safety_active
);

    localparam int SUM_W    = amat_pkg::SUM_W;
    localparam int CH_IDX_W = (CHANNELS > 4) ? 3 : ((CHANNELS > 2) ? 2 : 1);
    localparam int WU_W     = $clog2(AVG_COUNT + 1);
    localparam int SAFE_CH  = (CHANNELS < 7) ? CHANNELS : 7;
    localparam int DIV_SHIFT = SUM_W + $clog2(AVG_COUNT);
    localparam logic [SUM_W:0] DIV_MUL =
        (SUM_W + 1)'(((1 << DIV_SHIFT) + AVG_COUNT - 1) / AVG_COUNT);
    localparam logic [WU_W-1:0] AVG_LIMIT = WU_W'(AVG_COUNT);

    logic [SUM_W-1:0]       sum_reg  [CHANNELS];
    logic [SAMPLE_BITS-1:0] avg_reg  [CHANNELS];
    logic [SAMPLE_BITS-1:0] last_raw_reg [CHANNELS];
    logic [WU_W-1:0]        warm_reg [CHANNELS];

    logic [CH_IDX_W-1:0]    idx;
    logic [SUM_W-1:0]       sum_cur, sum_new;
    logic [SAMPLE_BITS-1:0] avg_cur, avg_new, avg_div;
    logic [WU_W-1:0]        warm_cur, warm_new;
    logic                   warming, ready_new;
    logic [2*SUM_W:0]       prod;
    logic [2*SUM_W:0]       quot;
    logic                   safety_new;
    logic [SAMPLE_BITS-1:0] raw_c;

    logic                          valid_reg;
    logic [amat_pkg::CH_W-1:0]     chan_reg;
    logic [SAMPLE_BITS-1:0]        raw_reg;
    logic [SAMPLE_BITS-1:0]        filt_reg;
    logic                          ready_reg;
    logic                          in_range_reg;
    logic                          rau_reg;
    logic                          rbl_reg;
    logic                          safety_reg;

    assign pop = head_valid && (!valid_reg || !result_stall);
    assign idx = head_channel[CH_IDX_W-1:0];

    always_comb
    begin
        sum_cur  = sum_reg[idx];
        avg_cur  = avg_reg[idx];
        warm_cur = warm_reg[idx];
        warming  = (warm_cur < AVG_LIMIT);
        if (warming)
        begin
            sum_new  = sum_cur + SUM_W'(head_sample);
            warm_new = warm_cur + WU_W'(1);
        end
        else
        begin
            sum_new  = sum_cur - SUM_W'(avg_cur) + SUM_W'(head_sample);
            warm_new = warm_cur;
        end
        prod      = (2*SUM_W+1)'(sum_new) * (2*SUM_W+1)'(DIV_MUL);
        quot      = prod >> DIV_SHIFT;
        avg_div   = quot[SAMPLE_BITS-1:0];
        ready_new = (warm_new >= AVG_LIMIT);
        avg_new   = ready_new ? avg_div : avg_cur;
    end

    always_comb
    begin
        safety_new = 1'b0;
        raw_c      = '0;
        for (int c = 0; c < SAFE_CH; c++)
        begin
            if (head_class.in_range && head_channel == amat_pkg::CH_W'(c))
                raw_c = head_sample;
            else
                raw_c = last_raw_reg[c];
            if (thr.mask[c] && (amat_pkg::THR_W'(raw_c) <
                                amat_pkg::lower_of(thr, amat_pkg::CH_W'(c))))
                safety_new = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c]      <= '0;
                avg_reg[c]      <= '0;
                last_raw_reg[c] <= '0;
                warm_reg[c]     <= '0;
            end
        end
        else if (pop && head_class.in_range)
        begin
            sum_reg[idx]      <= sum_new;
            avg_reg[idx]      <= avg_new;
            last_raw_reg[idx] <= head_sample;
            warm_reg[idx]     <= warm_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (!result_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            chan_reg     <= head_channel;
            raw_reg      <= head_sample;
            filt_reg     <= head_class.in_range ? avg_new : '0;
            ready_reg    <= head_class.in_range && ready_new;
            in_range_reg <= head_class.in_range;
            rau_reg      <= head_class.raw_above;
            rbl_reg      <= head_class.raw_below;
            safety_reg   <= safety_new;
        end
    end

    assign result_valid         = valid_reg;
    assign out_channel          = chan_reg;
    assign raw_value            = raw_reg;
    assign filtered_value       = filt_reg;
    assign filter_ready         = ready_reg;
    assign raw_above_upper      = rau_reg;
    assign raw_below_lower      = rbl_reg;
    assign filtered_above_upper = in_range_reg &&
        (amat_pkg::THR_W'(filt_reg) > amat_pkg::upper_of(thr, chan_reg));
    assign filtered_below_lower = in_range_reg &&
        (amat_pkg::THR_W'(filt_reg) < amat_pkg::lower_of(thr, chan_reg));
    assign safety_active        = safety_reg;

`ifndef ASSERT_OFF
    a_zero_before_ready: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !ready_reg |-> filt_reg == '0)
        else $error("filtered value nonzero before warm-up ends");
    a_last_raw_kept: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head_class.in_range |=> last_raw_reg[$past(idx)] == $past(head_sample))
        else $error("last raw value not recorded");
`endif

endmodule

FILE: src/multichannel_adc_average_threshold.sv
// Top level of the multichannel ADC averaging and threshold block.
// Depends on amat_pkg, amat_config, amat_front and amat_back.
//
//   Channel  | Handshake                   | Payload
//   samples  | sample_valid / sample_stall | channel, sample
//   results  | result_valid / result_stall | out_channel .. safety_active
//   config   | cfg_write                   | cfg_index, cfg_data
//
// One sample is taken every cycle when nothing stalls; it is written into the queue and
// then into the result register, from which it leaves when result_stall is low.
// The rate is set by the combinational per-channel update (add, subtract, reciprocal multiply).
// A two-entry queue sits between classification and update, so up to two samples are
// taken while a result is stalled. Reset clears the per-channel state and empties the queue.
module multichannel_adc_average_threshold #(
    parameter int CHANNELS    = 7,
    parameter int AVG_COUNT   = 10,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [amat_pkg::CH_W-1:0]     cfg_index,
    input  logic [amat_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [amat_pkg::CH_W-1:0]     channel,
    input  logic [SAMPLE_BITS-1:0]        sample,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [amat_pkg::CH_W-1:0]     out_channel,
    output logic [SAMPLE_BITS-1:0]        raw_value,
    output logic [SAMPLE_BITS-1:0]        filtered_value,
    output logic                          filter_ready,
    output logic                          raw_above_upper,
    output logic                          raw_below_lower,
    output logic                          filtered_above_upper,
    output logic                          filtered_below_lower,
    output logic                          safety_active
);

    amat_pkg::thr_t            thr;
    logic                      head_valid;
    logic [amat_pkg::CH_W-1:0] head_channel;
    logic [SAMPLE_BITS-1:0]    head_sample;
    amat_pkg::class_t          head_class;
    logic                      pop;

    amat_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .thr       (thr)
    );

    amat_front #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .thr          (thr),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .channel      (channel),
        .sample       (sample),
        .head_valid   (head_valid),
        .head_channel (head_channel),
        .head_sample  (head_sample),
        .head_class   (head_class),
        .pop          (pop)
    );

    amat_back #(
        .CHANNELS    (CHANNELS),
        .AVG_COUNT   (AVG_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .thr                  (thr),
        .head_valid           (head_valid),
        .head_channel         (head_channel),
        .head_sample          (head_sample),
        .head_class           (head_class),
        .pop                  (pop),
        .result_valid         (result_valid),
        .result_stall         (result_stall),
        .out_channel          (out_channel),
        .raw_value            (raw_value),
        .filtered_value       (filtered_value),
        .filter_ready         (filter_ready),
        .raw_above_upper      (raw_above_upper),
        .raw_below_lower      (raw_below_lower),
        .filtered_above_upper (filtered_above_upper),
        .filtered_below_lower (filtered_below_lower),
        .safety_active        (safety_active)
    );

endmodule

FILE: tb/sv/multichannel_adc_average_threshold_test.sv
// Self-checking testbench for multichannel_adc_average_threshold: drives ADC samples,
// predicts each result from a per-channel running-average model and compares fields.
// Depends on amat_pkg and the multichannel_adc_average_threshold RTL.
module multichannel_adc_average_threshold_test;
    import amat_pkg::*;

    localparam int SAMPLE_W = 12;
    localparam int NUM_CH = 7;
    localparam int AVG_LEN = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 250;

    typedef struct packed {
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] raw;
        logic [SAMPLE_W-1:0] filt;
        logic                ready;
        logic                raw_above;
        logic                raw_below;
        logic                filt_above;
        logic                filt_below;
        logic                safety;
    } adc_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    cfg_index_t          cfg_index = CFG_UPPER_LO;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                sample_valid = 1'b0;
    logic                sample_stall;
    logic [CH_W-1:0]     channel = '0;
    logic [SAMPLE_W-1:0] sample = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [CH_W-1:0]     out_channel;
    logic [SAMPLE_W-1:0] raw_value;
    logic [SAMPLE_W-1:0] filtered_value;
    logic                filter_ready;
    logic                raw_above_upper;
    logic                raw_below_lower;
    logic                filtered_above_upper;
    logic                filtered_below_lower;
    logic                safety_active;

    logic [CFG_W-1:0]    upper_lo_reg = 64'h09C4_09C4_09C4_09C4;
    logic [HI_W-1:0]     upper_hi_reg = 48'h09C4_09C4_09C4;
    logic [CFG_W-1:0]    lower_lo_reg = 64'h0000_03E8_03E8_0064;
    logic [HI_W-1:0]     lower_hi_reg = 48'h03E8_03E8_0000;
    logic [MASK_W-1:0]   mask_reg = 7'h66;

    logic [SUM_W-1:0]    running_sum [NUM_CH];
    logic [SAMPLE_W-1:0] average [NUM_CH];
    logic [SAMPLE_W-1:0] last_raw [NUM_CH];
    logic [3:0]          warm_count [NUM_CH];

    adc_result_t         expected_results [$];
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  cycle_count = 0;
    int                  error_count = 0;
    int                  items_sent = 0;
    int                  results_checked = 0;
    int                  settings_applied = 0;

    multichannel_adc_average_threshold i_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_write            (cfg_write),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .sample_valid         (sample_valid),
        .sample_stall         (sample_stall),
        .channel              (channel),
        .sample               (sample),
        .result_valid         (result_valid),
        .result_stall         (result_stall),
        .out_channel          (out_channel),
        .raw_value            (raw_value),
        .filtered_value       (filtered_value),
        .filter_ready         (filter_ready),
        .raw_above_upper      (raw_above_upper),
        .raw_below_lower      (raw_below_lower),
        .filtered_above_upper (filtered_above_upper),
        .filtered_below_lower (filtered_below_lower),
        .safety_active        (safety_active)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [THR_W-1:0] threshold_of(input logic [CFG_W-1:0] lo,
                                                      input logic [HI_W-1:0] hi,
                                                      input logic [CH_W-1:0] ch,
                                                      input logic [THR_W-1:0] none);
        if (ch < 4)
            return lo[16*ch +: 16];
        else if (ch < NUM_CH)
            return hi[16*(ch-4) +: 16];
        return none;
    endfunction

    function automatic logic [THR_W-1:0] upper_limit(input logic [CH_W-1:0] ch);
        return threshold_of(upper_lo_reg, upper_hi_reg, ch, 16'hFFFF);
    endfunction

    function automatic logic [THR_W-1:0] lower_limit(input logic [CH_W-1:0] ch);
        return threshold_of(lower_lo_reg, lower_hi_reg, ch, 16'h0000);
    endfunction

    function automatic logic masked_channel_low();
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (mask_reg[c] && last_raw[c] < lower_limit(CH_W'(c)))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic adc_result_t predict_adc_result(input logic [CH_W-1:0] ch,
                                                       input logic [SAMPLE_W-1:0] s);
        adc_result_t r;
        logic [THR_W-1:0] up;
        logic [THR_W-1:0] lo;
        r = '0;
        r.ch = ch;
        r.raw = s;
        if (ch < NUM_CH)
        begin
            up = upper_limit(ch);
            lo = lower_limit(ch);
            if (warm_count[ch] < AVG_LEN)
            begin
                running_sum[ch] = running_sum[ch] + SUM_W'(s);
                warm_count[ch] = warm_count[ch] + 4'd1;
                if (warm_count[ch] >= AVG_LEN)
                    average[ch] = SAMPLE_W'(running_sum[ch] / AVG_LEN);
            end
            else
            begin
                running_sum[ch] = running_sum[ch] - SUM_W'(average[ch]) + SUM_W'(s);
                average[ch] = SAMPLE_W'(running_sum[ch] / AVG_LEN);
            end
            last_raw[ch] = s;
            r.filt = average[ch];
            r.ready = (warm_count[ch] >= AVG_LEN);
            r.raw_above = (s > up);
            r.raw_below = (s < lo);
            r.filt_above = (r.filt > up);
            r.filt_below = (r.filt < lo);
        end
        r.safety = masked_channel_low();
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 30)
            $display("cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_field(input string field, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
    endtask

    task automatic check_result;
        adc_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("result transfer on channel %0d with none pending",
                                      out_channel));
        end
        else
        begin
            want = expected_results.pop_front();
            results_checked++;
            check_field("out_channel", 16'(out_channel), 16'(want.ch));
            check_field("raw_value", 16'(raw_value), 16'(want.raw));
            check_field("filtered_value", 16'(filtered_value), 16'(want.filt));
            check_field("filter_ready", 16'(filter_ready), 16'(want.ready));
            check_field("raw_above_upper", 16'(raw_above_upper), 16'(want.raw_above));
            check_field("raw_below_lower", 16'(raw_below_lower), 16'(want.raw_below));
            check_field("filtered_above_upper", 16'(filtered_above_upper),
                        16'(want.filt_above));
            check_field("filtered_below_lower", 16'(filtered_below_lower),
                        16'(want.filt_below));
            check_field("safety_active", 16'(safety_active), 16'(want.safety));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            check_result();
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] value);
        if ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        sample_valid <= 1'b1;
        channel <= ch;
        sample <= value;
        do @(posedge clk); while (sample_stall);
        expected_results.push_back(predict_adc_result(ch, value));
        items_sent++;
    endtask

    task automatic wait_for_results;
        sample_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] up_lo, input logic [CFG_W-1:0] up_hi,
                                  input logic [CFG_W-1:0] low_lo, input logic [CFG_W-1:0] low_hi,
                                  input logic [CFG_W-1:0] mask);
        wait_for_results();
        cfg_write <= 1'b1;
        write_register(CFG_UPPER_LO, up_lo);
        write_register(CFG_UPPER_HI, up_hi);
        write_register(CFG_LOWER_LO, low_lo);
        write_register(CFG_LOWER_HI, low_hi);
        write_register(CFG_SAFETY, mask);
        cfg_write <= 1'b0;
        upper_lo_reg = up_lo;
        upper_hi_reg = up_hi[HI_W-1:0];
        lower_lo_reg = low_lo;
        lower_hi_reg = low_hi[HI_W-1:0];
        mask_reg = mask[MASK_W-1:0];
        settings_applied++;
    endtask

    function automatic logic [THR_W-1:0] random_threshold();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return THR_W'($urandom);
            default: return THR_W'($urandom_range(4095));
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample(input int level);
        int v;
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3: return SAMPLE_W'($urandom);
            default:
            begin
                v = level + int'($urandom_range(256)) - 128;
                if (v < 0)
                    v = 0;
                if (v > 4095)
                    v = 4095;
                return SAMPLE_W'(v);
            end
        endcase
    endfunction

    task automatic test_reset_state;
        for (int c = 0; c < 8; c++)
            send_sample(CH_W'(c), c[0] ? 12'hFFF : 12'h000);
    endtask

    task automatic test_warmup_to_ready;
        repeat (10)
            send_sample(3'd4, 12'hFFF);
        send_sample(3'd4, 12'h000);
    endtask

    task automatic test_register_extremes;
        apply_settings('0, '0, '0, '0, '0);
        send_sample(3'd4, 12'hFFF);
        send_sample(3'd0, 12'h000);
        apply_settings('1, '1, '1, '1, '1);
        send_sample(3'd2, 12'hFFF);
        send_sample(3'd7, 12'hFFF);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        logic [CFG_W-1:0] up_lo;
        logic [CFG_W-1:0] low_lo;
        logic [HI_W-1:0]  up_hi;
        logic [HI_W-1:0]  low_hi;
        logic [CH_W-1:0]  ch;
        int               level;
        for (int i = 0; i < 4; i++)
        begin
            up_lo[16*i +: 16] = random_threshold();
            low_lo[16*i +: 16] = random_threshold();
        end
        for (int i = 0; i < 3; i++)
        begin
            up_hi[16*i +: 16] = random_threshold();
            low_hi[16*i +: 16] = random_threshold();
        end
        apply_settings(up_lo, {16'($urandom), up_hi}, low_lo, {16'($urandom), low_hi},
                       {$urandom, $urandom});
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        level = $urandom_range(4095);
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            ch = ($urandom_range(15) == 0) ? 3'd7 : CH_W'($urandom_range(NUM_CH - 1));
            send_sample(ch, random_sample(level));
        end
        wait_for_results();
    endtask

    initial
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            running_sum[c] = '0;
            average[c] = '0;
            last_raw[c] = '0;
            warm_count[c] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_warmup_to_ready();
        test_register_extremes();
        test_random_traffic(0, 0);
        test_random_traffic(65, 0);
        test_random_traffic(0, 65);
        test_random_traffic(23, 23);
        test_random_traffic(0, 0);
        test_random_traffic(65, 65);

        wait_for_results();
        repeat (4) @(posedge clk);
        $display("Sent %0d samples over %0d register settings; %0d results compared.",
                 items_sent, settings_applied, results_checked);
        $display("Covered warm-up, steady averaging, out-of-range channel and stall phases.");
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
